>>> sv/assert_macros.svh
// Assertion macros used by the comb filter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, switched off while reset is asserted.
`define FCF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked property that also holds while reset is asserted.
`define FCF_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

>>> sv/fcf_pkg.sv
// Constants, types and arithmetic helpers of the feedback comb filter.
`default_nettype none

package fcf_pkg;

  localparam int unsigned DelayDepth = 4096;
  localparam int unsigned SampleW    = 16;
  localparam int unsigned AddrW      = $clog2(DelayDepth);
  localparam int unsigned DelayW     = 12;
  localparam int unsigned GainW      = 16;
  localparam int unsigned QShift     = 15;
  localparam int unsigned QOne       = 32768;
  localparam int unsigned ProdW      = SampleW + GainW + 1;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [DelayW-1:0] DelayReset = DelayW'(800);
  localparam logic [GainW-1:0]  FbReset    = GainW'(16384);
  localparam logic [GainW-1:0]  MixReset   = GainW'(32768);
  localparam logic [GainW-1:0]  GainOne    = GainW'(QOne);

  localparam logic signed [ProdW-1:0] RoundHalf = ProdW'(QOne / 2);
  localparam logic signed [ProdW-1:0] SatMax    = ProdW'((64'sd1 <<< (SampleW - 1)) - 1);
  localparam logic signed [ProdW-1:0] SatMin    = -SatMax - ProdW'(1);

  typedef enum logic [CfgIdxW-1:0] {
    CfgDelay    = 2'd0,
    CfgFeedback = 2'd1,
    CfgMix      = 2'd2
  } cfg_idx_e;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [ProdW-1:0]   wide_t;

  // Settings as the datapath uses them, already limited to their legal ranges.
  typedef struct packed {
    logic [AddrW-1:0] delay;
    logic [GainW-1:0] fb_gain;
    logic [GainW-1:0] wet_gain;
  } cfg_t;

  function automatic sample_t saturate(wide_t v);
    sample_t r;
    if (v > SatMax) begin
      r = SatMax[SampleW-1:0];
    end else if (v < SatMin) begin
      r = SatMin[SampleW-1:0];
    end else begin
      r = v[SampleW-1:0];
    end
    return r;
  endfunction

  // Q1.15 product back to a sample: round half up, then clip.
  function automatic sample_t round_product(wide_t p);
    wide_t r;
    r = (p + RoundHalf) >>> QShift;
    return saturate(r);
  endfunction

  function automatic sample_t add_sat(sample_t a, sample_t b);
    wide_t s;
    s = ProdW'(a) + ProdW'(b);
    return saturate(s);
  endfunction

  function automatic wide_t mul_gain(sample_t s, logic [GainW-1:0] g);
    wide_t a;
    wide_t b;
    a = ProdW'(s);
    b = ProdW'(signed'({1'b0, g}));
    return a * b;
  endfunction

endpackage

`default_nettype wire

>>> sv/fcf_cfg_regs.sv
// Configuration registers of the comb filter, with range limiting of each setting.
`default_nettype none

module fcf_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [fcf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [fcf_pkg::CfgDataW-1:0] cfg_wdata_i,
  output fcf_pkg::cfg_t                     cfg_o
);

  logic [fcf_pkg::DelayW-1:0] delay_q;
  logic [fcf_pkg::GainW-1:0]  fb_q;
  logic [fcf_pkg::GainW-1:0]  mix_q;
  logic [fcf_pkg::GainW-1:0]  mix_lim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= fcf_pkg::DelayReset;
      fb_q    <= fcf_pkg::FbReset;
      mix_q   <= fcf_pkg::MixReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fcf_pkg::CfgDelay:    delay_q <= cfg_wdata_i[fcf_pkg::DelayW-1:0];
        fcf_pkg::CfgFeedback: fb_q    <= cfg_wdata_i[fcf_pkg::GainW-1:0];
        fcf_pkg::CfgMix:      mix_q   <= cfg_wdata_i[fcf_pkg::GainW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // A delay of zero behaves as one; a delay past the memory is held at its end.
    if (delay_q == '0) begin
      cfg_o.delay = fcf_pkg::AddrW'(1);
    end else if (32'(delay_q) > 32'(fcf_pkg::DelayDepth - 1)) begin
      cfg_o.delay = fcf_pkg::AddrW'(fcf_pkg::DelayDepth - 1);
    end else begin
      cfg_o.delay = fcf_pkg::AddrW'(delay_q);
    end

    cfg_o.fb_gain  = (fb_q > fcf_pkg::GainOne) ? fcf_pkg::GainOne : fb_q;
    mix_lim        = (mix_q > fcf_pkg::GainOne) ? fcf_pkg::GainOne : mix_q;
    cfg_o.wet_gain = fcf_pkg::GainOne - mix_lim;
  end

endmodule

`default_nettype wire

>>> sv/fcf_delay_ram.sv
// Delay line storage: one write port and one registered read port.
`default_nettype none

module fcf_delay_ram (
  input  wire logic                        clk_i,
  input  wire logic                        rd_en_i,
  input  wire logic [fcf_pkg::AddrW-1:0]   rd_addr_i,
  output fcf_pkg::sample_t                 rd_data_o,
  input  wire logic                        wr_en_i,
  input  wire logic [fcf_pkg::AddrW-1:0]   wr_addr_i,
  input  wire fcf_pkg::sample_t            wr_data_i
);

  fcf_pkg::sample_t mem_q [fcf_pkg::DelayDepth];
  fcf_pkg::sample_t rd_data_q;

  // A read and a write to the same entry in one cycle return the old contents.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> sv/feedback_comb_filter.sv
// Top level of the feedback comb filter: pipeline control, forwarding and output register.
`default_nettype none

// Feedback comb filter on signed Q1.15 samples. Each sample reads the entry written
// delay_samples transactions earlier, writes back the input plus the delayed value times
// feedback_gain (only the feedback term when trails is set), and returns the input plus
// the delayed value times one minus effect_mix, all saturated to 16 bits. A new sample is
// taken only while the first stage is empty; the first stage holds one sample until the
// preceding sample has written back and the multiply stage is free. A result passes the
// first and multiply stages and waits in an output register, while the next input is
// already taken. The memory is not swept after reset: a count of samples taken since
// reset marks which entries are still unwritten and read as zero, so the block is ready
// in the first cycle after reset.
module feedback_comb_filter (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [fcf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [fcf_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output wire logic                         in_ready_o,
  input  wire logic signed [15:0]           sample_in_i,
  input  wire logic                         trails_i,
  output wire logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output wire logic signed [15:0]           sample_out_o
);

  fcf_pkg::cfg_t cfg;

  logic                      in_fire;
  logic                      s1_move;
  logic                      s2_move;

  logic [fcf_pkg::AddrW-1:0] wp_q;
  logic [fcf_pkg::AddrW-1:0] fill_q;
  logic [fcf_pkg::AddrW-1:0] rd_addr;

  logic                      s1_valid_q;
  fcf_pkg::sample_t          s1_x_q;
  logic                      s1_trails_q;
  logic [fcf_pkg::AddrW-1:0] s1_rd_q;
  logic [fcf_pkg::AddrW-1:0] s1_wp_q;
  logic                      s1_hit_q;
  fcf_pkg::sample_t          rd_data;
  fcf_pkg::sample_t          delayed;

  logic                      s2_valid_q;
  fcf_pkg::sample_t          s2_x_q;
  logic                      s2_trails_q;
  logic [fcf_pkg::AddrW-1:0] s2_wp_q;
  fcf_pkg::wide_t            s2_fb_q;
  fcf_pkg::wide_t            s2_wet_q;

  fcf_pkg::sample_t          fb;
  fcf_pkg::sample_t          wet;
  fcf_pkg::sample_t          stored;

  logic                      wl_valid_q;
  logic [fcf_pkg::AddrW-1:0] wl_addr_q;
  fcf_pkg::sample_t          wl_data_q;

  logic                      out_valid_q;
  fcf_pkg::sample_t          sample_out_q;

  fcf_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign in_ready_o = !s1_valid_q;
  assign in_fire    = in_valid_i && !s1_valid_q;
  // The first stage only moves on once the sample ahead of it has written back.
  assign s1_move    = s1_valid_q && !s2_valid_q;
  assign s2_move    = s2_valid_q && (!out_valid_q || out_ready_i);
  assign rd_addr    = wp_q - cfg.delay;

  fcf_delay_ram u_delay_ram (
    .clk_i     (clk_i),
    .rd_en_i   (in_fire),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (s2_move),
    .wr_addr_i (s2_wp_q),
    .wr_data_i (stored)
  );

  // Write position and the count of samples taken since reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
    end else if (in_fire) begin
      wp_q <= wp_q + fcf_pkg::AddrW'(1);
      if (fill_q != '1) begin
        fill_q <= fill_q + fcf_pkg::AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_x_q      <= sample_in_i;
      s1_trails_q <= trails_i;
      s1_rd_q     <= rd_addr;
      s1_wp_q     <= wp_q;
      s1_hit_q    <= (fill_q >= cfg.delay);
    end
  end

  // An entry not yet written since reset reads as zero; a write that landed after
  // the read was issued is taken from the last-write register.
  always_comb begin
    if (!s1_hit_q) begin
      delayed = '0;
    end else if (wl_valid_q && (wl_addr_q == s1_rd_q)) begin
      delayed = wl_data_q;
    end else begin
      delayed = rd_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s1_move) begin
      s2_valid_q <= 1'b1;
    end else if (s2_move) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      s2_x_q      <= s1_x_q;
      s2_trails_q <= s1_trails_q;
      s2_wp_q     <= s1_wp_q;
      s2_fb_q     <= fcf_pkg::mul_gain(delayed, cfg.fb_gain);
      s2_wet_q    <= fcf_pkg::mul_gain(delayed, cfg.wet_gain);
    end
  end

  always_comb begin
    fb     = fcf_pkg::round_product(s2_fb_q);
    wet    = fcf_pkg::round_product(s2_wet_q);
    stored = s2_trails_q ? fb : fcf_pkg::add_sat(s2_x_q, fb);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (s2_move) begin
      wl_valid_q  <= 1'b1;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_move) begin
      wl_addr_q    <= s2_wp_q;
      wl_data_q    <= stored;
      sample_out_q <= fcf_pkg::add_sat(s2_x_q, wet);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;

  `include "assert_macros.svh"

  `FCF_ASSERT_ALWAYS(a_reset_empties, !rst_ni |=> !s1_valid_q && !s2_valid_q && !out_valid_q, "pipeline not empty after reset")
  `FCF_ASSERT(a_s1_waits_for_s2, s1_valid_q && s2_valid_q |=> s1_valid_q, "first stage left while write-back pending")
  `FCF_ASSERT(a_s2_holds_on_stall, s2_valid_q && out_valid_q && !out_ready_i |=> s2_valid_q && $stable(s2_wp_q), "second stage lost on output stall")
  `FCF_ASSERT(a_fill_saturates, fill_q == '1 |=> fill_q == '1, "fill count wrapped")
  `FCF_ASSERT(a_fill_tracks_wp, fill_q != '1 |-> fill_q == wp_q, "fill count and write position disagree")

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the feedback comb filter: directed table, random phases, scoreboard.
`timescale 1ns / 1ps

module testbench;
  import fcf_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnusedIdx = CfgIdxW'(3);
  localparam int unsigned        EchoDepth    = 4096;
  localparam int                 PlanLen      = 23;
  localparam int                 RandPhases   = 12;
  localparam int                 PhaseItems   = 75;

  typedef enum logic {StepRegs, StepSample} step_kind_e;

  // For a register step v0..v2 are delay, feedback and mix, and poke also writes the
  // unused index. For a sample step v0 is the sample and v1 the expected output when pin is set.
  typedef struct packed {
    step_kind_e  kind;
    logic        poke;
    logic        tr;
    logic        pin;
    logic [15:0] v0;
    logic [15:0] v1;
    logic [15:0] v2;
  } step_t;

  typedef struct packed {
    logic    on;
    sample_t value;
  } pinned_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  sample_t             sample_in_i = '0;
  logic                trails_i    = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  sample_t             sample_out_o;

  feedback_comb_filter u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_in_i (sample_in_i),
    .trails_i    (trails_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sample_out_o(sample_out_o)
  );

  always #5 clk_i = ~clk_i;

  step_t plan [PlanLen] = '{
    '{StepSample, 1'b0, 1'b0, 1'b1, 16'h7FFF, 16'h7FFF, 16'h0000},
    '{StepSample, 1'b0, 1'b0, 1'b1, 16'h8000, 16'h8000, 16'h0000},
    '{StepSample, 1'b0, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000},
    '{StepSample, 1'b0, 1'b0, 1'b1, 16'h0001, 16'h0001, 16'h0000},
    '{StepSample, 1'b0, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'h0000},
    // Zero delay behaves as one, full feedback and a fully wet output.
    '{StepRegs,   1'b0, 1'b0, 1'b0, 16'd0,    16'd32768, 16'd0},
    '{StepSample, 1'b0, 1'b0, 1'b0, 16'h4000, 16'h0000, 16'h0000},
    '{StepSample, 1'b0, 1'b0, 1'b1, 16'h7FFF, 16'h7FFF, 16'h0000},
    '{StepSample, 1'b0, 1'b1, 1'b0, 16'h8000, 16'h0000, 16'h0000},
    '{StepSample, 1'b0, 1'b0, 1'b0, 16'h8000, 16'h0000, 16'h0000},
    '{StepSample, 1'b0, 1'b0, 1'b1, 16'h8000, 16'h8000, 16'h0000},
    // Longest delay; gains above one are clipped, so the output is the dry input.
    '{StepRegs,   1'b0, 1'b0, 1'b0, 16'd4095, 16'd65535, 16'd40000},
    '{StepSample, 1'b0, 1'b0, 1'b1, 16'd12345, 16'd12345, 16'h0000},
    '{StepSample, 1'b0, 1'b1, 1'b1, 16'hCFC7, 16'hCFC7, 16'h0000},
    '{StepSample, 1'b0, 1'b0, 1'b1, 16'h5555, 16'h5555, 16'h0000},
    '{StepSample, 1'b0, 1'b0, 1'b1, 16'hAAAA, 16'hAAAA, 16'h0000},
    // A write to the unused index must change nothing; upper delay bits are dropped.
    '{StepRegs,   1'b1, 1'b0, 1'b0, 16'hF003, 16'd1,    16'd1},
    '{StepSample, 1'b0, 1'b0, 1'b0, 16'h7FFF, 16'h0000, 16'h0000},
    '{StepSample, 1'b0, 1'b0, 1'b0, 16'h8000, 16'h0000, 16'h0000},
    '{StepSample, 1'b0, 1'b1, 1'b0, 16'd100,  16'h0000, 16'h0000},
    '{StepSample, 1'b0, 1'b0, 1'b0, 16'hFF9C, 16'h0000, 16'h0000},
    '{StepSample, 1'b0, 1'b1, 1'b0, 16'h7FFF, 16'h0000, 16'h0000},
    '{StepSample, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000}
  };

  // Mirror of the filter state and settings.
  sample_t          echo_mem [EchoDepth];
  logic [AddrW-1:0] echo_wr_pos;
  logic [DelayW-1:0] cur_delay;
  logic [GainW-1:0] cur_fb;
  logic [GainW-1:0] cur_mix;

  sample_t   expected_out_q [$];
  pinned_t   pinned_q [$];
  sample_t   mon_want;
  pinned_t   mon_pin;
  int        errors;
  int        samples_taken;
  int        trails_taken;
  int        outputs_seen;
  int        settings_used;
  int unsigned sender_pct;
  int unsigned recv_pct;

  function automatic longint clip_sample(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Q1.15 product, rounded half up and clipped.
  function automatic longint q15_scale(longint s, int unsigned g);
    longint p;
    p = s * longint'(g) + 16384;
    return clip_sample(p >>> 15);
  endfunction

  function automatic sample_t comb_output(sample_t x, logic tr);
    int unsigned      d;
    int unsigned      fbg;
    int unsigned      mixg;
    logic [AddrW-1:0] rd;
    longint           delayed;
    longint           fb;
    longint           wet;
    d    = (cur_delay == 0) ? 1 : cur_delay;
    fbg  = (cur_fb > QOne) ? QOne : cur_fb;
    mixg = (cur_mix > QOne) ? QOne : cur_mix;
    rd = echo_wr_pos - AddrW'(d);
    delayed = echo_mem[rd];
    fb = q15_scale(delayed, fbg);
    echo_mem[echo_wr_pos] = sample_t'(tr ? fb : clip_sample(longint'(x) + fb));
    echo_wr_pos = echo_wr_pos + 1'b1;
    wet = q15_scale(delayed, QOne - mixg);
    return sample_t'(clip_sample(longint'(x) + wet));
  endfunction

  always @(posedge clk_i) begin
    out_ready_i <= (recv_pct == 0) || ($urandom_range(99) >= recv_pct);
  end

  // Scoreboard: register mirror, output check, then prediction for the accepted input.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgDelay:    cur_delay = cfg_wdata_i[DelayW-1:0];
          CfgFeedback: cur_fb = cfg_wdata_i;
          CfgMix:      cur_mix = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_o && out_ready_i) begin
        outputs_seen++;
        if (expected_out_q.size() == 0) begin
          errors++;
          $display("%0t: output %0d with none expected", $time, sample_out_o);
        end else begin
          mon_want = expected_out_q.pop_front();
          if (sample_out_o !== mon_want) begin
            errors++;
            $display("%0t: sample_out expected %0d, got %0d", $time, mon_want, sample_out_o);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        samples_taken++;
        if (trails_i) trails_taken++;
        mon_want = comb_output(sample_in_i, trails_i);
        mon_pin = pinned_q.pop_front();
        if (mon_pin.on) mon_want = mon_pin.value;
        expected_out_q.push_back(mon_want);
      end
    end
  end

  task automatic send_sample(input sample_t x, input logic tr, input logic pin, input sample_t pv);
    if (sender_pct != 0 && $urandom_range(99) < sender_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_pct);
    end
    pinned_q.push_back('{on: pin, value: pv});
    in_valid_i  <= 1'b1;
    sample_in_i <= x;
    trails_i    <= tr;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stops the sender and waits until every predicted output has arrived.
  task automatic settle_pipeline();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_out_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [15:0] dly, input logic [15:0] fb,
                              input logic [15:0] mix, input logic poke);
    settings_used++;
    cfg_we_i <= 1'b1;
    if (poke) begin
      cfg_index_i <= CfgUnusedIdx;
      cfg_wdata_i <= 16'hFFFF;
      @(posedge clk_i);
    end
    cfg_index_i <= CfgDelay;
    cfg_wdata_i <= dly;
    @(posedge clk_i);
    cfg_index_i <= CfgFeedback;
    cfg_wdata_i <= fb;
    @(posedge clk_i);
    cfg_index_i <= CfgMix;
    cfg_wdata_i <= mix;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_gain();
    int unsigned r;
    r = $urandom_range(7);
    if (r == 0) return 16'd0;
    if (r == 1) return GainOne;
    if (r == 2) return 16'($urandom);
    if (r == 3) return 16'($urandom_range(QOne));
    return 16'($urandom_range(QOne, 16384));
  endfunction

  function automatic logic [15:0] pick_delay();
    int unsigned r;
    logic [15:0] hi;
    r  = $urandom_range(9);
    hi = 16'($urandom) & 16'hF000;
    if (r == 0) return hi;
    if (r == 1) return hi | 16'd4095;
    if (r == 2) return 16'($urandom);
    return hi | 16'($urandom_range(48, 1));
  endfunction

  function automatic sample_t pick_sample();
    int unsigned r;
    r = $urandom_range(7);
    if (r == 0) return 16'sh7FFF;
    if (r == 1) return 16'sh8000;
    if (r == 2) return sample_t'($urandom_range(128) - 64);
    return sample_t'($urandom);
  endfunction

  initial begin
    int ph;
    int n;
    int w;
    for (int i = 0; i < EchoDepth; i++) echo_mem[i] = '0;
    echo_wr_pos = '0;
    cur_delay = DelayReset;
    cur_fb    = FbReset;
    cur_mix   = MixReset;
    errors = 0;
    samples_taken = 0;
    trails_taken = 0;
    outputs_seen = 0;
    settings_used = 1;
    sender_pct = 0;
    recv_pct = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (n = 0; n < PlanLen; n++) begin
      if (plan[n].kind == StepRegs) begin
        settle_pipeline();
        program_regs(plan[n].v0, plan[n].v1, plan[n].v2, plan[n].poke);
      end else begin
        send_sample(sample_t'(plan[n].v0), plan[n].tr, plan[n].pin, sample_t'(plan[n].v1));
      end
    end

    for (ph = 0; ph < RandPhases; ph++) begin
      settle_pipeline();
      program_regs(pick_delay(), pick_gain(), pick_gain(), 1'b0);
      case (ph % 4)
        0: begin sender_pct = 0;  recv_pct = 0;  end
        1: begin sender_pct = 52; recv_pct = 0;  end
        2: begin sender_pct = 0;  recv_pct = 52; end
        default: begin sender_pct = 29; recv_pct = 29; end
      endcase
      for (n = 0; n < PhaseItems; n++) begin
        // In one phase the sender holds off midway until the filter has emptied.
        if (ph == 5 && n == PhaseItems / 2) settle_pipeline();
        send_sample(pick_sample(), ($urandom_range(3) == 0), 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    // Let the scoreboard record the last accepted transaction before counting.
    @(posedge clk_i);
    for (w = 0; w < 5000 && expected_out_q.size() != 0; w++) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (expected_out_q.size() != 0) begin
      errors++;
      $display("%0t: %0d expected outputs never arrived", $time, expected_out_q.size());
    end
    $display("Run covered %0d samples (%0d in trails mode) under %0d register settings.",
             samples_taken, trails_taken, settings_used);
    $display("%0d outputs compared, %0d mismatches.", outputs_seen, errors);
    if (errors == 0) begin
      $display("PASS feedback_comb_filter");
    end else begin
      $display("FAIL feedback_comb_filter");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL feedback_comb_filter");
    $finish;
  end

endmodule
